/* src/blle_pkg.sv */
// ----------------------------------------------------------------------------
// Binary lifting LCA engine - shared definitions
// Sizes, operation codes and the command/status bundles exchanged between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package blle_pkg;

    localparam int MAX_NODES = 1024;
    localparam int LEVELS    = 11;

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int KCNT_W    = $clog2(LEVELS + 1);
    localparam int NCNT_W    = $clog2(MAX_NODES + 1);
    localparam int ANC_W     = NODE_W + 1;
    localparam int TAB_DEPTH = LEVELS * MAX_NODES;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);

    // fixed interface field widths
    localparam int OP_W  = 2;
    localparam int ID_W  = 10;
    localparam int PAR_W = 11;
    localparam int DEP_W = 11;
    localparam int CFG_W = 11;

    // table entry: MSB set means no ancestor
    localparam logic [ANC_W-1:0] ANC_NONE = '1;
    localparam logic [ID_W-1:0]  ANS_NONE = '1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RA_BJ   = 2'd0,   // level k-1, node j
        RA_BMID = 2'd1,   // level k-1, node read in previous cycle
        RA_P    = 2'd2,   // level i, node p
        RA_P0   = 2'd3    // level 0, node p
    } ra_sel_t;

    typedef enum logic [1:0] {
        WR_CLR   = 2'd0,
        WR_LOAD  = 2'd1,
        WR_BUILD = 2'd2
    } wr_sel_t;

    typedef enum logic [1:0] {
        RES_NONE = 2'd0,
        RES_P    = 2'd1,
        RES_TAB  = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic     clr_next;
        logic     tab_wr;
        wr_sel_t  wr_sel;
        logic     tab_rd_a;
        ra_sel_t  ra_sel;
        logic     tab_rd_b;
        logic     dep_wr;
        logic     dep_rd_in;
        logic     dep_rd_lift;
        logic     build_init;
        logic     build_next_node;
        logic     build_next_level;
        logic     mid_capture;
        logic     q_order;
        logic     p1_take_dep;
        logic     p2_update;
        logic     i_dec;
        logic     i_reload;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic j_last;
        logic level_ok;
        logic q_bad;
        logic p1_cond;
        logic i_zero;
        logic anc_a_none;
        logic p_eq_q;
        logic out_free;
    } status_t;

endpackage

/* src/blle_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module blle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a_reg <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* src/blle_ctrl.sv */
// ----------------------------------------------------------------------------
// Binary lifting LCA engine - controller
// Sequences the reset clear, node loads, table build and queries.
// ----------------------------------------------------------------------------
module blle_ctrl import blle_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [OP_W-1:0] s_op,
    output logic            s_ready,
    input  status_t         status,
    output cmd_t            cmd
);

    typedef enum logic [15:0] {
        ST_CLEAR   = 16'h0001,
        ST_IDLE    = 16'h0002,
        ST_B_CHECK = 16'h0004,
        ST_B_RD1   = 16'h0008,
        ST_B_RD2   = 16'h0010,
        ST_B_WR    = 16'h0020,
        ST_Q_DEP   = 16'h0040,
        ST_P1_EVAL = 16'h0080,
        ST_P1_ANC  = 16'h0100,
        ST_P1_DEP  = 16'h0200,
        ST_P1_END  = 16'h0400,
        ST_P2_RD   = 16'h0800,
        ST_P2_UPD  = 16'h1000,
        ST_F_RD    = 16'h2000,
        ST_F_RES   = 16'h4000,
        ST_Q_OUT   = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.tab_wr   = 1'b1;
                cmd.wr_sel   = WR_CLR;
                cmd.clr_next = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_op)
                        OP_LOAD: begin
                            cmd.tab_wr = 1'b1;
                            cmd.wr_sel = WR_LOAD;
                            cmd.dep_wr = 1'b1;
                        end
                        OP_BUILD: begin
                            cmd.build_init = 1'b1;
                            state_next     = ST_B_CHECK;
                        end
                        OP_QUERY: begin
                            cmd.dep_rd_in = 1'b1;
                            state_next    = ST_Q_DEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_B_CHECK: begin
                state_next = status.level_ok ? ST_B_RD1 : ST_IDLE;
            end
            ST_B_RD1: begin
                cmd.tab_rd_a = 1'b1;
                cmd.ra_sel   = RA_BJ;
                state_next   = ST_B_RD2;
            end
            ST_B_RD2: begin
                cmd.mid_capture = 1'b1;
                cmd.tab_rd_a    = 1'b1;
                cmd.ra_sel      = RA_BMID;
                state_next      = ST_B_WR;
            end
            ST_B_WR: begin
                cmd.tab_wr = 1'b1;
                cmd.wr_sel = WR_BUILD;
                if (status.j_last) begin
                    cmd.build_next_level = 1'b1;
                    state_next           = ST_B_CHECK;
                end else begin
                    cmd.build_next_node = 1'b1;
                    state_next          = ST_B_RD1;
                end
            end
            ST_Q_DEP: begin
                if (status.q_bad) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_NONE;
                    state_next   = ST_Q_OUT;
                end else begin
                    cmd.q_order = 1'b1;
                    state_next  = ST_P1_EVAL;
                end
            end
            ST_P1_EVAL: begin
                if (status.p1_cond) begin
                    cmd.tab_rd_a = 1'b1;
                    cmd.ra_sel   = RA_P;
                    state_next   = ST_P1_ANC;
                end else if (status.i_zero) begin
                    state_next = ST_P1_END;
                end else begin
                    cmd.i_dec = 1'b1;
                end
            end
            ST_P1_ANC: begin
                if (!status.anc_a_none) begin
                    cmd.dep_rd_lift = 1'b1;
                    state_next      = ST_P1_DEP;
                end else if (status.i_zero) begin
                    state_next = ST_P1_END;
                end else begin
                    cmd.i_dec  = 1'b1;
                    state_next = ST_P1_EVAL;
                end
            end
            ST_P1_DEP: begin
                cmd.p1_take_dep = 1'b1;
                if (status.i_zero) begin
                    state_next = ST_P1_END;
                end else begin
                    cmd.i_dec  = 1'b1;
                    state_next = ST_P1_EVAL;
                end
            end
            ST_P1_END: begin
                if (status.p_eq_q) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_P;
                    state_next   = ST_Q_OUT;
                end else begin
                    cmd.i_reload = 1'b1;
                    state_next   = ST_P2_RD;
                end
            end
            ST_P2_RD: begin
                cmd.tab_rd_a = 1'b1;
                cmd.ra_sel   = RA_P;
                cmd.tab_rd_b = 1'b1;
                state_next   = ST_P2_UPD;
            end
            ST_P2_UPD: begin
                cmd.p2_update = 1'b1;
                if (status.i_zero) begin
                    state_next = ST_F_RD;
                end else begin
                    cmd.i_dec  = 1'b1;
                    state_next = ST_P2_RD;
                end
            end
            ST_F_RD: begin
                cmd.tab_rd_a = 1'b1;
                cmd.ra_sel   = RA_P0;
                state_next   = ST_F_RES;
            end
            ST_F_RES: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_TAB;
                state_next   = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/blle_dpath.sv */
// ----------------------------------------------------------------------------
// Binary lifting LCA engine - datapath
// Ancestor table and depth store, lifting registers, result register.
// ----------------------------------------------------------------------------
module blle_dpath import blle_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic                    cfg_wr_en,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic [ID_W-1:0]         s_node_a,
    input  logic [ID_W-1:0]         s_node_b,
    input  logic signed [PAR_W-1:0] s_parent_node,
    input  logic [DEP_W-1:0]        s_node_level,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ID_W-1:0]         m_ancestor
);

    // Levels above the last build, and nodes at or above the build's node
    // count on levels 1 and up, read as no ancestor.
    function automatic logic [ANC_W-1:0] anc_mask(
        input logic [ANC_W-1:0]  raw,
        input logic [LVL_W-1:0]  lvl,
        input logic [NODE_W-1:0] node,
        input logic [LVL_W-1:0]  blvl,
        input logic [NCNT_W-1:0] bn
    );
        logic stale;
        stale = (lvl != '0) && ((lvl > blvl) || (NCNT_W'(node) >= bn));
        return stale ? ANC_NONE : raw;
    endfunction

    function automatic logic [TAB_AW-1:0] tab_addr(
        input logic [LVL_W-1:0]  lvl,
        input logic [NODE_W-1:0] node
    );
        return TAB_AW'(TAB_AW'(lvl) * TAB_AW'(MAX_NODES)) + TAB_AW'(node);
    endfunction

    logic [CFG_W-1:0]  node_count_reg;
    logic [NCNT_W-1:0] built_n_reg;
    logic [LVL_W-1:0]  built_lvl_reg;
    logic [KCNT_W-1:0] k_reg;
    logic [NODE_W-1:0] j_reg;
    logic              m_valid_reg;

    logic [NODE_W-1:0] a_reg, b_reg, p_reg, q_reg;
    logic [DEP_W-1:0]  dp_reg, dq_reg;
    logic [LVL_W-1:0]  i_reg, lg_reg;
    logic              q_bad_reg;
    logic              mid_none_reg;
    logic [ID_W-1:0]   res_reg, m_ancestor_reg;
    logic [LVL_W-1:0]  rd_lvl_a_reg, rd_lvl_b_reg;
    logic [NODE_W-1:0] rd_node_a_reg, rd_node_b_reg;

    logic [ANC_W-1:0]  tab_rdata_a, tab_rdata_b, anc_a, anc_b;
    logic [DEP_W-1:0]  dep_rdata_a, dep_rdata_b;
    logic [KCNT_W-1:0] k_m1;
    logic [LVL_W-1:0]  ra_lvl, wr_lvl, lg_calc;
    logic [NODE_W-1:0] ra_node, wr_node, node_a_idx;
    logic [ANC_W-1:0]  wr_data, par_entry;
    logic              tab_we, load_ok, par_ok, swap, p2_move;
    logic [DEP_W-1:0]  d_max;

    assign anc_a = anc_mask(tab_rdata_a, rd_lvl_a_reg, rd_node_a_reg, built_lvl_reg,
                            built_n_reg);
    assign anc_b = anc_mask(tab_rdata_b, rd_lvl_b_reg, rd_node_b_reg, built_lvl_reg,
                            built_n_reg);

    assign k_m1       = k_reg - 1'b1;
    assign node_a_idx = NODE_W'(s_node_a);
    assign load_ok    = (32'(s_node_a) < 32'(MAX_NODES));
    assign par_ok     = !s_parent_node[PAR_W-1]
                        && (32'(s_parent_node[PAR_W-2:0]) < 32'(MAX_NODES));
    assign par_entry  = par_ok ? {1'b0, NODE_W'(s_parent_node[PAR_W-2:0])} : ANC_NONE;

    // table read port A address
    always_comb begin
        case (cmd.ra_sel)
            RA_BJ: begin
                ra_lvl  = k_m1[LVL_W-1:0];
                ra_node = j_reg;
            end
            RA_BMID: begin
                ra_lvl  = k_m1[LVL_W-1:0];
                ra_node = anc_a[NODE_W-1:0];
            end
            RA_P: begin
                ra_lvl  = i_reg;
                ra_node = p_reg;
            end
            default: begin
                ra_lvl  = '0;
                ra_node = p_reg;
            end
        endcase
    end

    // table write port
    always_comb begin
        tab_we  = 1'b0;
        wr_lvl  = '0;
        wr_node = j_reg;
        wr_data = ANC_NONE;
        case (cmd.wr_sel)
            WR_CLR: begin
                tab_we = cmd.tab_wr;
            end
            WR_LOAD: begin
                tab_we  = cmd.tab_wr & load_ok;
                wr_node = node_a_idx;
                wr_data = par_entry;
            end
            WR_BUILD: begin
                tab_we  = cmd.tab_wr;
                wr_lvl  = k_reg[LVL_W-1:0];
                wr_data = mid_none_reg ? ANC_NONE : anc_a;
            end
            default: begin
                tab_we = 1'b0;
            end
        endcase
    end

    blle_ram #(
        .WIDTH (ANC_W),
        .DEPTH (TAB_DEPTH)
    ) u_tab_ram (
        .aclk    (aclk),
        .we      (tab_we),
        .waddr   (tab_addr(wr_lvl, wr_node)),
        .wdata   (wr_data),
        .re_a    (cmd.tab_rd_a),
        .raddr_a (tab_addr(ra_lvl, ra_node)),
        .rdata_a (tab_rdata_a),
        .re_b    (cmd.tab_rd_b),
        .raddr_b (tab_addr(i_reg, q_reg)),
        .rdata_b (tab_rdata_b)
    );

    blle_ram #(
        .WIDTH (DEP_W),
        .DEPTH (MAX_NODES)
    ) u_dep_ram (
        .aclk    (aclk),
        .we      (cmd.dep_wr & load_ok),
        .waddr   (node_a_idx),
        .wdata   (s_node_level),
        .re_a    (cmd.dep_rd_in | cmd.dep_rd_lift),
        .raddr_a (cmd.dep_rd_lift ? anc_a[NODE_W-1:0] : node_a_idx),
        .rdata_a (dep_rdata_a),
        .re_b    (cmd.dep_rd_in),
        .raddr_b (NODE_W'(s_node_b)),
        .rdata_b (dep_rdata_b)
    );

    // highest lifting level for the deeper node
    assign swap  = (dep_rdata_b > dep_rdata_a);
    assign d_max = swap ? dep_rdata_b : dep_rdata_a;

    always_comb begin
        lg_calc = LVL_W'(1);
        for (int l = 1; l < LEVELS - 1; l++) begin
            if ((32'd1 << l) < 32'(d_max)) begin
                lg_calc = LVL_W'(l + 1);
            end
        end
    end

    assign p2_move = !anc_a[NODE_W] && !anc_b[NODE_W] && (anc_a != anc_b);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CFG_W'(1);
            built_n_reg    <= '0;
            built_lvl_reg  <= '0;
            k_reg          <= KCNT_W'(1);
            j_reg          <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                node_count_reg <= cfg_wr_data;
            end
            if (cmd.build_init) begin
                built_n_reg   <= (32'(node_count_reg) > 32'(MAX_NODES))
                                 ? NCNT_W'(MAX_NODES) : NCNT_W'(node_count_reg);
                built_lvl_reg <= '0;
                k_reg         <= KCNT_W'(1);
            end else if (cmd.build_next_level) begin
                built_lvl_reg <= k_reg[LVL_W-1:0];
                k_reg         <= k_reg + 1'b1;
            end
            if (cmd.build_init || cmd.build_next_level) begin
                j_reg <= '0;
            end else if (cmd.clr_next || cmd.build_next_node) begin
                j_reg <= j_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // query working registers
    always_ff @(posedge aclk) begin
        if (cmd.tab_rd_a) begin
            rd_lvl_a_reg  <= ra_lvl;
            rd_node_a_reg <= ra_node;
        end
        if (cmd.tab_rd_b) begin
            rd_lvl_b_reg  <= i_reg;
            rd_node_b_reg <= q_reg;
        end
        if (cmd.mid_capture) begin
            mid_none_reg <= anc_a[NODE_W];
        end
        if (cmd.dep_rd_in) begin
            a_reg     <= node_a_idx;
            b_reg     <= NODE_W'(s_node_b);
            q_bad_reg <= (32'(s_node_a) >= 32'(MAX_NODES))
                         || (32'(s_node_b) >= 32'(MAX_NODES));
        end
        if (cmd.q_order) begin
            p_reg  <= swap ? b_reg : a_reg;
            q_reg  <= swap ? a_reg : b_reg;
            dp_reg <= swap ? dep_rdata_b : dep_rdata_a;
            dq_reg <= swap ? dep_rdata_a : dep_rdata_b;
            lg_reg <= lg_calc;
        end else if (cmd.dep_rd_lift) begin
            p_reg <= anc_a[NODE_W-1:0];
        end else if (cmd.p2_update && p2_move) begin
            p_reg <= anc_a[NODE_W-1:0];
            q_reg <= anc_b[NODE_W-1:0];
        end
        if (cmd.p1_take_dep) begin
            dp_reg <= dep_rdata_a;
        end
        if (cmd.q_order) begin
            i_reg <= lg_calc;
        end else if (cmd.i_reload) begin
            i_reg <= lg_reg;
        end else if (cmd.i_dec) begin
            i_reg <= i_reg - 1'b1;
        end
        if (cmd.res_load) begin
            case (cmd.res_sel)
                RES_P:   res_reg <= ID_W'(p_reg);
                RES_TAB: res_reg <= anc_a[NODE_W] ? ANS_NONE : ID_W'(anc_a[NODE_W-1:0]);
                default: res_reg <= ANS_NONE;
            endcase
        end
        if (cmd.out_load) begin
            m_ancestor_reg <= res_reg;
        end
    end

    assign status.clr_last   = (j_reg == NODE_W'(MAX_NODES - 1));
    assign status.j_last     = (NCNT_W'(j_reg) == (built_n_reg - 1'b1));
    assign status.level_ok   = (k_reg < KCNT_W'(LEVELS))
                               && ((32'd1 << k_reg) < 32'(built_n_reg));
    assign status.q_bad      = q_bad_reg;
    assign status.p1_cond    = (32'(dq_reg) + (32'd1 << i_reg)) <= 32'(dp_reg);
    assign status.i_zero     = (i_reg == '0);
    assign status.anc_a_none = anc_a[NODE_W];
    assign status.p_eq_q     = (p_reg == q_reg);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_ancestor = m_ancestor_reg;

endmodule

/* src/binary_lifting_lca_engine.sv */
// ----------------------------------------------------------------------------
// Binary lifting lowest common ancestor engine
// After reset the engine clears level 0 of its ancestor table, one node per
// cycle, and holds s_ready low meanwhile. A load is taken in the idle state
// and the engine stays idle. A build fills each level by two table reads and
// one write per node. A query uses L = lg + 1 lifting levels (lg set by the
// depth of the deeper node, at most 10) and ends early when the two nodes
// meet while the deeper one is lifted; its time is set by the chain of
// dependent reads through the ancestor table RAM, whose read data is
// registered, and by the depth lookups. Items are processed one at a time;
// a finished result waits in the output register while the next transaction
// is accepted. node_count is to be written only while the engine is idle;
// the engine itself does not enforce this.
// ----------------------------------------------------------------------------
module binary_lifting_lca_engine import blle_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_op,
    input  logic [ID_W-1:0]         s_node_a,
    input  logic [ID_W-1:0]         s_node_b,
    input  logic signed [PAR_W-1:0] s_parent_node,
    input  logic [DEP_W-1:0]        s_node_level,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [ID_W-1:0]         m_ancestor
);

    cmd_t    cmd;
    status_t status;

    blle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    blle_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_node_a      (s_node_a),
        .s_node_b      (s_node_b),
        .s_parent_node (s_parent_node),
        .s_node_level  (s_node_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ancestor    (m_ancestor)
    );

endmodule

/* src/blle_checker.sv */
// ----------------------------------------------------------------------------
// Binary lifting LCA engine - port checker
// Watches the top-level ports and tracks queries still owed a result.
// ----------------------------------------------------------------------------
module blle_checker import blle_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    cfg_wr_en,
    input logic [CFG_W-1:0]        cfg_wr_data,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [OP_W-1:0]         s_op,
    input logic [ID_W-1:0]         s_node_a,
    input logic [ID_W-1:0]         s_node_b,
    input logic signed [PAR_W-1:0] s_parent_node,
    input logic [DEP_W-1:0]        s_node_level,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [ID_W-1:0]         m_ancestor
);

    logic [1:0] pend_reg;
    logic       query_acc;
    logic       res_acc;

    assign query_acc = s_valid && s_ready && (s_op == OP_QUERY);
    assign res_acc   = m_valid && m_ready;

    // queries accepted minus results delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + {1'b0, query_acc} - {1'b0, res_acc};
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ancestor))
        else $error("result changed or dropped while stalled");

    a_no_stray_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result without an outstanding query");

    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("more than two queries outstanding");

    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input accepted during table clear");

    a_busy_after_long_op: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_BUILD || s_op == OP_QUERY) |=> !s_ready)
        else $error("ready right after a build or query");

endmodule

bind binary_lifting_lca_engine blle_checker u_blle_checker (.*);

/* bench/lca_checker.sv */
// ----------------------------------------------------------------------------
// LCA engine checker
// Watches the node_count port and both channels of the engine. Keeps its own
// ancestor table, depth store and node_count, predicts the answer of every
// query transaction and compares the answers in order of arrival.
// ----------------------------------------------------------------------------
module lca_checker import blle_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [OP_W-1:0]         s_op,
    input  logic [ID_W-1:0]         s_node_a,
    input  logic [ID_W-1:0]         s_node_b,
    input  logic signed [PAR_W-1:0] s_parent_node,
    input  logic [DEP_W-1:0]        s_node_level,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [ID_W-1:0]         m_ancestor,
    output int                      mismatches,
    output int                      awaiting,
    output int                      answers_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ANC_W-1:0] anc_tab [LEVELS][MAX_NODES];
    logic [DEP_W-1:0] depth_mem [MAX_NODES];
    logic [CFG_W-1:0] node_limit;
    logic [ID_W-1:0]  answers_due [$];

    initial begin
        mismatches   = 0;
        awaiting     = 0;
        answers_seen = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_model();
        int k, j;
        for (k = 0; k < LEVELS; k++)
            for (j = 0; j < MAX_NODES; j++)
                anc_tab[k][j] = ANC_NONE;
        for (j = 0; j < MAX_NODES; j++)
            depth_mem[j] = '0;
        node_limit = 1;
    endfunction

    function automatic int depth_of(input int node);
        depth_of = depth_mem[node];
    endfunction

    function automatic void rebuild_levels();
        int n, k, j;
        logic [ANC_W-1:0] mid;
        n = (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
        for (k = 1; k < LEVELS; k++)
            for (j = 0; j < MAX_NODES; j++)
                anc_tab[k][j] = ANC_NONE;
        // level k exists only while its span stays below node_count
        for (k = 1; k < LEVELS && (1 << k) < n; k++) begin
            for (j = 0; j < n; j++) begin
                mid = anc_tab[k-1][j];
                if (mid != ANC_NONE)
                    anc_tab[k][j] = anc_tab[k-1][mid[ID_W-1:0]];
            end
        end
    endfunction

    function automatic logic [ID_W-1:0] lca_of(input int na, input int nb);
        int p, q, t, lg, i;
        logic [ANC_W-1:0] r, ap, aq;
        p = na;
        q = nb;
        if (depth_of(q) > depth_of(p)) begin
            t = p;
            p = q;
            q = t;
        end
        lg = 1;
        while (lg < LEVELS - 1 && (1 << lg) < depth_of(p))
            lg++;
        // depth is re-read after each lift; missing ancestors are skipped
        for (i = lg; i >= 0; i--) begin
            if (depth_of(p) - (1 << i) >= depth_of(q)) begin
                r = anc_tab[i][p];
                if (r != ANC_NONE)
                    p = r;
            end
        end
        if (p == q)
            return p[ID_W-1:0];
        for (i = lg; i >= 0; i--) begin
            ap = anc_tab[i][p];
            aq = anc_tab[i][q];
            if (ap != ANC_NONE && aq != ANC_NONE && ap != aq) begin
                p = ap;
                q = aq;
            end
        end
        r = anc_tab[0][p];
        return (r == ANC_NONE) ? ANS_NONE : r[ID_W-1:0];
    endfunction

    always @(posedge aclk) begin
        logic [ID_W-1:0] want;
        if (!aresetn) begin
            clear_model();
            answers_due.delete();
            awaiting <= 0;
        end else begin
            if (cfg_wr_en)
                node_limit = cfg_wr_data;
            if (m_valid && m_ready) begin
                answers_seen++;
                if (answers_due.size() == 0) begin
                    report_mismatch($sformatf("ancestor %0d with no query pending",
                                              m_ancestor));
                end else begin
                    want = answers_due.pop_front();
                    if (m_ancestor !== want)
                        report_mismatch($sformatf("ancestor got %0d, want %0d",
                                                  m_ancestor, want));
                end
            end
            if (s_valid && s_ready) begin
                case (s_op)
                    OP_LOAD: begin
                        // negative parent means root, stored as no ancestor
                        anc_tab[0][s_node_a] = s_parent_node[PAR_W-1] ? ANC_NONE
                                                                      : s_parent_node;
                        depth_mem[s_node_a] = s_node_level;
                    end
                    OP_BUILD: rebuild_levels();
                    OP_QUERY: answers_due = {answers_due, lca_of(s_node_a, s_node_b)};
                    default: ;
                endcase
            end
            awaiting <= answers_due.size();
        end
    end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Binary lifting LCA engine testbench
// Loads rooted trees (plus some malformed nodes), builds the ancestor table
// under a range of node_count settings and fires queries at it, with random
// idle bursts on both channels. The lca_checker instance predicts and checks
// every answer; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import blle_pkg::*;

    localparam int ITEMS         = 700;
    localparam int GAP_END       = 560;     // no idling past this many items
    localparam int QUIET_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD     = 300;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_W-1:0]        cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [OP_W-1:0]         s_op;
    logic [ID_W-1:0]         s_node_a;
    logic [ID_W-1:0]         s_node_b;
    logic signed [PAR_W-1:0] s_parent_node;
    logic [DEP_W-1:0]        s_node_level;
    logic                    m_valid;
    logic                    m_ready;
    logic [ID_W-1:0]         m_ancestor;

    int mismatches, awaiting, answers_seen;

    bit tx_gaps, rx_gaps, hold_req;
    bit hold_taken   = 1'b0;
    int stall_left   = 0;
    int quiet_cycles = 0;
    int n_loads = 0, n_builds = 0, n_queries = 0, n_nops = 0, max_depth = 0;

    bit loaded [MAX_NODES];
    int loaded_ids [$];

    binary_lifting_lca_engine dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_node_a      (s_node_a),
        .s_node_b      (s_node_b),
        .s_parent_node (s_parent_node),
        .s_node_level  (s_node_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ancestor    (m_ancestor)
    );

    lca_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_node_a      (s_node_a),
        .s_node_b      (s_node_b),
        .s_parent_node (s_parent_node),
        .s_node_level  (s_node_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ancestor    (m_ancestor),
        .mismatches    (mismatches),
        .awaiting      (awaiting),
        .answers_seen  (answers_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int items_sent();
        return n_loads + n_builds + n_queries;
    endfunction

    // result side: random stall bursts, plus one long hold-off on request
    initial m_ready <= 1'b0;

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            stall_left <= LONG_HOLD - 1;
            m_ready    <= 1'b0;
        end else if (rx_gaps && items_sent() < GAP_END && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("no transaction for %0d cycles", QUIET_LIMIT);
            $display("FAIL binary_lifting_lca_engine");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int pick_loaded();
        return loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
    endfunction

    task automatic send_item(input op_t op, input int a, input int b,
                             input int par, input int lvl);
        if (tx_gaps && items_sent() < GAP_END && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_node_a      <= a[ID_W-1:0];
        s_node_b      <= b[ID_W-1:0];
        s_parent_node <= par[PAR_W-1:0];
        s_node_level  <= lvl[DEP_W-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        case (op)
            OP_LOAD:  n_loads++;
            OP_BUILD: n_builds++;
            OP_QUERY: n_queries++;
            default:  n_nops++;
        endcase
    endtask

    task automatic send_load(input int node, input int par, input int lvl);
        if (!loaded[node]) begin
            loaded[node] = 1'b1;
            loaded_ids = {loaded_ids, node};
        end
        send_item(OP_LOAD, node, $urandom_range(0, 1023), par, lvl);
    endtask

    task automatic send_query(input int a, input int b);
        send_item(OP_QUERY, a, b, $urandom_range(0, 2047), $urandom_range(0, 2047));
    endtask

    task automatic send_build();
        send_item(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 2047), $urandom_range(0, 2047));
    endtask

    task automatic set_node_count(input int v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // occasional junk: ignored op, malformed load, query on any loaded node
    task automatic maybe_noise();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            send_item(OP_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 2047), $urandom_range(0, 2047));
        else if (r == 1)
            send_load($urandom_range(0, 1023),
                      $urandom_range(0, 1) ? pick_loaded() : $urandom_range(1024, 2047),
                      $urandom_range(0, 2047));
        else if (r == 2)
            send_query(pick_loaded(), pick_loaded());
    endtask

    // a query as fence: once its answer is back the engine is idle
    task automatic end_phase();
        send_query(pick_loaded(), pick_loaded());
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input int nc, input bit long_hold, input bit deep);
        int n_eff, lim, size, roots, base, k, pi, id, nq, a, b;
        int ids [$];
        int deps [$];
        bit used [MAX_NODES];
        set_node_count(nc);
        n_eff = (nc > MAX_NODES) ? MAX_NODES : nc;
        lim = (n_eff < 8) ? 32 : n_eff;
        // sometimes place nodes beyond the span that the build covers
        if ($urandom_range(0, 3) == 0)
            lim = (lim + 16 > MAX_NODES) ? MAX_NODES : lim + 16;
        size = deep ? 130 : $urandom_range(6, 40);
        if (size > lim)
            size = lim;
        roots = deep ? 1 : (($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1);
        base = ($urandom_range(0, 2) == 0 || deep) ? $urandom_range(1, 1000) : 1;
        while (ids.size() < size) begin
            id = $urandom_range(0, lim - 1);
            if (!used[id]) begin
                used[id] = 1'b1;
                ids = {ids, id};
            end
        end
        // parents are always loaded before their children
        for (k = 0; k < size; k++) begin
            if (k < roots) begin
                deps = {deps, base};
                send_load(ids[k], -1, base);
            end else begin
                if (deep)
                    pi = ($urandom_range(0, 7) != 0) ? k - 1 : $urandom_range(0, k - 1);
                else if ($urandom_range(0, 1) && k > 3)
                    pi = $urandom_range(k - 3, k - 1);
                else
                    pi = $urandom_range(0, k - 1);
                deps = {deps, deps[pi] + 1};
                send_load(ids[k], ids[pi], deps[pi] + 1);
                if (deps[pi] + 1 > max_depth)
                    max_depth = deps[pi] + 1;
            end
            maybe_noise();
        end
        send_build();
        if (long_hold)
            hold_req <= 1'b1;
        nq = deep ? 100 : 3 * size;
        for (k = 0; k < nq; k++) begin
            if (k == nq / 2 && $urandom_range(0, 2) == 0) begin
                send_load(ids[size-1], ids[0], deps[0] + 1);
                send_build();
            end
            a = ids[$urandom_range(0, size - 1)];
            case ($urandom_range(0, 9))
                0:       b = a;
                1:       b = pick_loaded();
                default: b = ids[$urandom_range(0, size - 1)];
            endcase
            send_query(a, b);
            maybe_noise();
        end
        end_phase();
    endtask

    initial begin
        int phase;
        int plan [$];
        plan = {1, 2047, 3, 1024, 2, 40, 9};
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_valid       <= 1'b0;
        s_op          <= OP_NOP;
        s_node_a      <= '0;
        s_node_b      <= '0;
        s_parent_node <= '0;
        s_node_level  <= '0;
        tx_gaps       <= 1'b1;
        rx_gaps       <= 1'b1;
        hold_req      <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // level 0 clearing pass after reset keeps s_ready low
        do @(posedge aclk); while (!s_ready);

        // small hand-built tree: 0 - {1 - 2 - 4, 3 - 5}; 1023 stands alone
        set_node_count(8);
        send_item(OP_NOP, 1023, 1023, 2047, 2047);
        send_load(0, -1, 1);
        send_load(1, 0, 2);
        send_load(2, 1, 3);
        send_load(3, 0, 2);
        send_load(4, 2, 4);
        send_load(5, 3, 3);
        send_load(1023, -1024, 1024);
        send_query(4, 5);
        send_build();
        send_query(4, 5);
        send_query(2, 4);
        send_query(4, 4);
        send_query(5, 4);
        send_query(1023, 0);
        send_query(0, 1023);
        send_query(0, 0);
        send_item(OP_NOP, 0, 0, 0, 0);
        end_phase();

        phase = 0;
        while (items_sent() < ITEMS) begin
            // one phase without idling, and none near the end
            tx_gaps <= (phase != 3) && (items_sent() < GAP_END);
            rx_gaps <= (phase != 3) && (items_sent() < GAP_END);
            run_phase((phase < plan.size()) ? plan[phase] : $urandom_range(2, 100),
                      phase == 2, phase == 3);
            phase++;
        end

        $display("covered %0d loads, %0d builds, %0d queries (%0d answers), %0d no-ops",
                 n_loads, n_builds, n_queries, answers_seen, n_nops);
        $display("%0d node_count settings from 1 to 2047, node depth up to %0d",
                 phase + 1, max_depth);
        if (mismatches == 0 && awaiting == 0)
            $display("PASS binary_lifting_lca_engine");
        else
            $display("FAIL binary_lifting_lca_engine");
        $finish;
    end

endmodule
